[hw/rtl/ppbq_pkg.sv]
// Shared types and constants for the ping-pong batch queue.
// No dependencies; ppbq_ctrl and ping_pong_batch_queue_unit import this package.
package ppbq_pkg;

    // Fixed port widths of the item fields and of the capacity.
    localparam int DATA_W = 32;
    localparam int CAP_W  = 9;
    localparam int FC_W   = 9;

    // Reset value of the capacity register.
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Operation carried by an input item.
    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_SWAP  = 2'd1,
        KIND_POP   = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    // Outcome reported by a result item.
    typedef enum logic [2:0] {
        ST_PUSH_FIRST = 3'd0,
        ST_PUSH_MORE  = 3'd1,
        ST_PUSH_FULL  = 3'd2,
        ST_POPPED     = 3'd3,
        ST_POP_EMPTY  = 3'd4,
        ST_SWAPPED    = 3'd5,
        ST_SWAP_IGN   = 3'd6,
        ST_CLEARED    = 3'd7
    } status_t;

    typedef struct packed {
        kind_t             kind;
        logic [DATA_W-1:0] push_data;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] pop_data;
        logic [FC_W-1:0]   fill_count;
        logic              fill_empty;
        logic              fill_full;
    } out_item_t;

    // Result fields known at the time an item is accepted; the popped word
    // joins them from the read register of the bank memory.
    typedef struct packed {
        status_t         status;
        logic [FC_W-1:0] fill_count;
        logic            fill_empty;
        logic            fill_full;
    } meta_t;

endpackage

[hw/rtl/ppbq_bank_mem.sv]
// Bank storage of the ping-pong batch queue: one synchronous memory that
// holds both banks, one write port and one registered read port.
// Uses no package items.
module ppbq_bank_mem #(
    parameter int WORD_WIDTH = 32,
    parameter int ADDR_W     = 9
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [WORD_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [WORD_WIDTH-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WORD_WIDTH-1:0] mem [DEPTH];
    logic [WORD_WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data register holds its word until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/ppbq_ctrl.sv]
// Bank control of the ping-pong batch queue: bank select, fill count and
// drain pointers, memory requests and the result status of each item.
// Depends on ppbq_pkg.
module ppbq_ctrl #(
    parameter int BANK_DEPTH = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  ppbq_pkg::in_item_t               in_item,
    input  logic [ppbq_pkg::CAP_W-1:0]       capacity,
    output logic                             mem_wr_en,
    output logic [$clog2(BANK_DEPTH):0]      mem_wr_addr,
    output logic [WORD_WIDTH-1:0]            mem_wr_data,
    output logic                             mem_rd_en,
    output logic [$clog2(BANK_DEPTH):0]      mem_rd_addr,
    output ppbq_pkg::meta_t                  meta
);

    import ppbq_pkg::*;

    localparam int IDX_W = $clog2(BANK_DEPTH);
    localparam int CNT_W = $clog2(BANK_DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic             fill_sel_reg;
    logic             fill_sel_next;
    logic [CNT_W-1:0] words_filled_reg;
    logic [CNT_W-1:0] words_filled_next;
    logic [CNT_W-1:0] drain_total_reg;
    logic [CNT_W-1:0] drain_total_next;
    logic [IDX_W-1:0] drain_index_reg;
    logic [IDX_W-1:0] drain_index_next;

    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] eff_cap;
    logic [CMP_W-1:0] filled_ext;
    logic [CMP_W-1:0] filled_next_ext;
    logic [CNT_W-1:0] drain_index_inc;
    logic             bank_full;
    status_t          status;

    // Capacity saturates at the bank depth.
    always_comb
    begin
        cap_ext = CMP_W'(capacity);
        if (cap_ext > CMP_W'(BANK_DEPTH))
        begin
            eff_cap = CMP_W'(BANK_DEPTH);
        end
        else
        begin
            eff_cap = cap_ext;
        end
        filled_ext      = CMP_W'(words_filled_reg);
        bank_full       = filled_ext >= eff_cap;
        drain_index_inc = CNT_W'(drain_index_reg) + CNT_W'(1);
    end

    // Per-item decision: counter updates, memory access and status.
    always_comb
    begin
        fill_sel_next     = fill_sel_reg;
        words_filled_next = words_filled_reg;
        drain_total_next  = drain_total_reg;
        drain_index_next  = drain_index_reg;
        mem_wr_en         = 1'b0;
        mem_rd_en         = 1'b0;
        mem_wr_addr       = {fill_sel_reg, words_filled_reg[IDX_W-1:0]};
        mem_rd_addr       = {~fill_sel_reg, drain_index_reg};
        mem_wr_data       = WORD_WIDTH'(in_item.push_data);
        status            = ST_CLEARED;

        unique case (in_item.kind)
            KIND_PUSH:
            begin
                if (bank_full)
                begin
                    status = ST_PUSH_FULL;
                end
                else
                begin
                    mem_wr_en         = accept;
                    words_filled_next = words_filled_reg + CNT_W'(1);
                    status = (words_filled_reg == '0) ? ST_PUSH_FIRST : ST_PUSH_MORE;
                end
            end
            KIND_SWAP:
            begin
                if (words_filled_reg == '0)
                begin
                    status = ST_SWAP_IGN;
                end
                else
                begin
                    fill_sel_next     = ~fill_sel_reg;
                    drain_total_next  = words_filled_reg;
                    drain_index_next  = '0;
                    words_filled_next = '0;
                    status            = ST_SWAPPED;
                end
            end
            KIND_POP:
            begin
                if (drain_total_reg == '0)
                begin
                    status = ST_POP_EMPTY;
                end
                else
                begin
                    mem_rd_en = accept;
                    status    = ST_POPPED;
                    if (drain_index_inc >= drain_total_reg)
                    begin
                        drain_total_next = '0;
                        drain_index_next = '0;
                    end
                    else
                    begin
                        drain_index_next = drain_index_inc[IDX_W-1:0];
                    end
                end
            end
            KIND_CLEAR:
            begin
                words_filled_next = '0;
                status            = ST_CLEARED;
            end
            default:
            begin
                status = ST_CLEARED;
            end
        endcase
    end

    // Fill-side flags as they stand after this item.
    always_comb
    begin
        filled_next_ext  = CMP_W'(words_filled_next);
        meta.status      = status;
        meta.fill_count  = FC_W'(words_filled_next);
        meta.fill_empty  = (words_filled_next == '0);
        meta.fill_full   = (filled_next_ext >= eff_cap);
    end

    // State registers advance only on an accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_sel_reg     <= 1'b0;
            words_filled_reg <= '0;
            drain_total_reg  <= '0;
            drain_index_reg  <= '0;
        end
        else if (accept)
        begin
            fill_sel_reg     <= fill_sel_next;
            words_filled_reg <= words_filled_next;
            drain_total_reg  <= drain_total_next;
            drain_index_reg  <= drain_index_next;
        end
    end

endmodule

[hw/rtl/ping_pong_batch_queue_unit.sv]
// Ping-pong batch queue: two banks in one memory, filled by pushes and
// handed to the drain side by a swap. Depends on ppbq_pkg, ppbq_ctrl and
// ppbq_bank_mem.
// A result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle; the result register and the memory read
// register form one stage, so input stalls only while a result is stalled.
// Reset clears counters, bank select and the result valid, and sets the
// capacity to 256; bank memory contents stay undefined, with no clearing pass.
module ping_pong_batch_queue_unit #(
    parameter int BANK_DEPTH = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  ppbq_pkg::in_item_t         in_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output ppbq_pkg::out_item_t        out_item,
    input  logic                       cfg_wr_en,
    input  logic [ppbq_pkg::CAP_W-1:0] cfg_wr_data
);

    import ppbq_pkg::*;

    localparam int ADDR_W = $clog2(BANK_DEPTH) + 1;

    logic                  accept;
    logic [CAP_W-1:0]      capacity_reg;
    logic                  res_valid_reg;
    meta_t                 res_meta_reg;
    meta_t                 meta;
    logic                  mem_wr_en;
    logic [ADDR_W-1:0]     mem_wr_addr;
    logic [WORD_WIDTH-1:0] mem_wr_data;
    logic                  mem_rd_en;
    logic [ADDR_W-1:0]     mem_rd_addr;
    logic [WORD_WIDTH-1:0] mem_rd_data;

    // An item enters whenever the result stage is empty or being taken.
    assign in_stall = res_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    ppbq_ctrl #(
        .BANK_DEPTH (BANK_DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_item     (in_item),
        .capacity    (capacity_reg),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .meta        (meta)
    );

    ppbq_bank_mem #(
        .WORD_WIDTH (WORD_WIDTH),
        .ADDR_W     (ADDR_W)
    ) u_bank_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Result stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            res_valid_reg <= in_valid;
        end
    end

    // Result stage payload; it holds while the result is stalled.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_meta_reg <= meta;
        end
    end

    // The popped word comes straight from the memory read register, which
    // only changes on an accepted pop.
    always_comb
    begin
        out_item.status     = res_meta_reg.status;
        out_item.fill_count = res_meta_reg.fill_count;
        out_item.fill_empty = res_meta_reg.fill_empty;
        out_item.fill_full  = res_meta_reg.fill_full;
        if (res_meta_reg.status == ST_POPPED)
        begin
            out_item.pop_data = DATA_W'(mem_rd_data);
        end
        else
        begin
            out_item.pop_data = '0;
        end
    end

    assign out_valid = res_valid_reg;

endmodule
